// ===== rtl/core/lsfr_pkg.sv =====
// Shared types, constants and pattern tables for the LED soft-start sequencer.
package lsfr_pkg;

	localparam int unsigned TICK_RATE_DEF = 62;
	localparam int unsigned RAMP_DIVISOR = 4;
	localparam int unsigned RANDOM_SPAN = 20;
	localparam int unsigned LIGHTER_STEP = 2;
	localparam int unsigned FLUOR_LEN = 13;
	localparam int unsigned LIGHTER_LEN = 6;

	localparam logic CMD_START = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	typedef enum logic [1:0] {
		MODE_INSTANT = 2'd0,
		MODE_LINEAR  = 2'd1,
		MODE_FLUOR   = 2'd2,
		MODE_LIGHTER = 2'd3
	} mode_t;

	// Phase durations in ticks. A zero entry stands for the random duration.
	// The tables are padded to the full position range; padding is never used.
	localparam logic [3:0] FLUOR_TAB [16] = '{
		4'd0, 4'd2, 4'd5, 4'd3, 4'd0, 4'd1, 4'd0, 4'd2,
		4'd0, 4'd5, 4'd14, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0
	};
	localparam logic [3:0] LIGHTER_TAB [16] = '{
		4'd5, 4'd2, 4'd12, 4'd2, 4'd0, 4'd1, 4'd0, 4'd0,
		4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0
	};

	typedef struct packed {
		logic [7:0] level;
		logic [7:0] target;
		logic [7:0] count;
		logic [3:0] pos;
		logic [4:0] rdur;
	} state_t;

	typedef struct packed {
		logic       cmd;
		logic [7:0] target_level;
		logic [7:0] random_byte;
	} in_t;

	typedef struct packed {
		logic [7:0] level;
		logic       thermal_target_set;
		logic       ramp_active;
	} out_t;

endpackage

// ===== rtl/core/lsfr_start.sv =====
// Start request handling: instant level set, ramp step and random phase duration.
module lsfr_start #(
	parameter int unsigned TICK_RATE = lsfr_pkg::TICK_RATE_DEF
) (
	input  lsfr_pkg::state_t cur,
	input  lsfr_pkg::mode_t  mode,
	input  logic [7:0]       target_level,
	input  logic [7:0]       random_byte,
	output lsfr_pkg::state_t nxt,
	output logic             therm
);

	localparam int unsigned StepDiv = TICK_RATE / lsfr_pkg::RAMP_DIVISOR;
	// Rounded-up reciprocals; exact for any 8-bit dividend at these divisors.
	localparam int unsigned StepRecip = (65536 + StepDiv - 1) / StepDiv;
	localparam int unsigned RandRecip =
		(65536 + lsfr_pkg::RANDOM_SPAN - 1) / lsfr_pkg::RANDOM_SPAN;

	logic [24:0] step_prod;
	logic [8:0]  step_sum;
	logic [7:0]  step_sat;
	logic [24:0] rand_prod;
	logic [7:0]  rand_quot;
	logic [7:0]  rand_rem;
	logic [4:0]  rdur;

	assign step_prod = {17'd0, target_level} * 25'(StepRecip);
	assign step_sum  = {1'b0, step_prod[23:16]} + 9'd1;
	assign step_sat  = step_sum[8] ? 8'hFF : step_sum[7:0];

	assign rand_prod = {17'd0, random_byte} * 25'(RandRecip);
	assign rand_quot = rand_prod[23:16];
	assign rand_rem  = random_byte - 8'(rand_quot * 8'(lsfr_pkg::RANDOM_SPAN));
	assign rdur      = rand_rem[4:0] + 5'd1;

	always_comb begin
		nxt   = cur;
		therm = 1'b0;
		unique case (mode)
			lsfr_pkg::MODE_LINEAR: begin
				nxt.target = target_level;
				nxt.count  = step_sat;
			end
			lsfr_pkg::MODE_FLUOR, lsfr_pkg::MODE_LIGHTER: begin
				nxt.target = target_level;
				nxt.rdur   = rdur;
				nxt.count  = 8'd0;
				nxt.pos    = 4'd0;
			end
			default: begin
				nxt.level = target_level;
				therm     = 1'b1;
			end
		endcase
	end

endmodule

// ===== rtl/core/lsfr_tick.sv =====
// Tick request handling: linear ramp, flicker pattern playback and final ramp.
module lsfr_tick (
	input  lsfr_pkg::state_t cur,
	input  lsfr_pkg::mode_t  mode,
	output lsfr_pkg::state_t nxt
);

	logic [7:0] cnt_inc;
	logic [3:0] entry;
	logic       in_table;
	logic       over;
	logic [3:0] pos_inc;
	logic [8:0] lin_sum;
	logic [8:0] lit_sum;
	logic [7:0] lit_level;
	lsfr_pkg::state_t adv;

	assign cnt_inc = cur.count + 8'd1;
	assign pos_inc = cur.pos + 4'd1;
	assign lin_sum = {1'b0, cur.level} + {1'b0, cur.count};

	always_comb begin
		if (mode == lsfr_pkg::MODE_FLUOR) begin
			entry    = lsfr_pkg::FLUOR_TAB[cur.pos];
			in_table = cur.pos < 4'(lsfr_pkg::FLUOR_LEN);
		end else begin
			entry    = lsfr_pkg::LIGHTER_TAB[cur.pos];
			in_table = cur.pos < 4'(lsfr_pkg::LIGHTER_LEN);
		end
		if (entry == 4'd0) begin
			over = cnt_inc == {3'd0, cur.rdur};
		end else begin
			over = cnt_inc == {4'd0, entry};
		end

		// Count the tick, then step to the next phase when this one is over.
		adv       = cur;
		adv.count = cnt_inc;
		if (in_table && over) begin
			adv.pos   = pos_inc;
			adv.count = 8'd0;
			adv.level = pos_inc[0] ? {1'b0, cur.target[7:1]} : 8'd0;
		end

		lit_sum   = {1'b0, adv.level} + 9'(lsfr_pkg::LIGHTER_STEP);
		lit_level = lit_sum[8] ? 8'hFF : lit_sum[7:0];

		nxt = cur;
		if (cur.target != 8'd0) begin
			unique case (mode)
				lsfr_pkg::MODE_LINEAR: begin
					if (cur.target > cur.level) begin
						if (lin_sum >= {1'b0, cur.target}) begin
							nxt.level  = cur.target;
							nxt.target = 8'd0;
						end else begin
							nxt.level = lin_sum[7:0];
						end
					end
				end
				lsfr_pkg::MODE_FLUOR: begin
					nxt = adv;
					if (adv.pos >= 4'(lsfr_pkg::FLUOR_LEN)) begin
						nxt.level  = cur.target;
						nxt.target = 8'd0;
						nxt.pos    = 4'd0;
					end
				end
				lsfr_pkg::MODE_LIGHTER: begin
					nxt = adv;
					if (adv.pos >= 4'(lsfr_pkg::LIGHTER_LEN)) begin
						nxt.level = lit_level;
						if (lit_level >= cur.target) begin
							nxt.level  = cur.target;
							nxt.target = 8'd0;
							nxt.pos    = 4'd0;
						end
					end
				end
				default: begin
					nxt = cur;
				end
			endcase
		end
	end

endmodule

// ===== rtl/core/led_startup_flicker_ramp_top.sv =====
// Top level of the LED soft-start sequencer: request register, state and result register.
//
//   Channel   Direction  Handshake             Payload
//   in        request    in_valid / in_ready   in_req  (lsfr_pkg::in_t)
//   out       result     out_valid / out_ready out_res (lsfr_pkg::out_t)
//   cfg       write      cfg_we                cfg_wdata (start mode)
//
// One request per clock is accepted unless the output stalls; its result is registered.
// The request register feeds a single combinational update of the sequencer
// state, which is stored together with the result on the same edge.
// When the result register is held by out_ready low, the request register
// holds too, and in_ready drops only while both are full.
// Reset clears the sequencer state, the mode and both valid flags.
module led_startup_flicker_ramp_top #(
	parameter int unsigned TICK_RATE = lsfr_pkg::TICK_RATE_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  lsfr_pkg::in_t    in_req,
	output logic             out_valid,
	input  logic             out_ready,
	output lsfr_pkg::out_t   out_res,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_wdata
);

	lsfr_pkg::in_t    req_s1;
	logic             valid_s1;
	lsfr_pkg::state_t state_q;
	lsfr_pkg::mode_t  mode_q;
	lsfr_pkg::out_t   res_q;
	logic             res_valid_q;

	lsfr_pkg::state_t start_nxt;
	lsfr_pkg::state_t tick_nxt;
	lsfr_pkg::state_t state_nxt;
	logic             start_therm;
	logic             advance;

	assign advance  = valid_s1 && (!res_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	lsfr_start #(
		.TICK_RATE(TICK_RATE)
	) u_start (
		.cur         (state_q),
		.mode        (mode_q),
		.target_level(req_s1.target_level),
		.random_byte (req_s1.random_byte),
		.nxt         (start_nxt),
		.therm       (start_therm)
	);

	lsfr_tick u_tick (
		.cur (state_q),
		.mode(mode_q),
		.nxt (tick_nxt)
	);

	assign state_nxt = (req_s1.cmd == lsfr_pkg::CMD_START) ? start_nxt : tick_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
			state_q     <= '0;
			mode_q      <= lsfr_pkg::MODE_INSTANT;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (!res_valid_q || out_ready) begin
				res_valid_q <= valid_s1;
			end
			if (advance) begin
				state_q <= state_nxt;
			end
			if (cfg_we) begin
				mode_q <= lsfr_pkg::mode_t'(cfg_wdata);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_s1 <= in_req;
		end
		if (advance) begin
			res_q.level              <= state_nxt.level;
			res_q.thermal_target_set <= (req_s1.cmd == lsfr_pkg::CMD_START) && start_therm;
			res_q.ramp_active        <= state_nxt.target != 8'd0;
		end
	end

	assign out_valid = res_valid_q;
	assign out_res   = res_q;

endmodule
